// ===== rtl/jbe_pkg.sv =====
// jbe_pkg: shared constants, types and small functions for the JPEG block
// entropy encoder. No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package jbe_pkg;

   localparam int JBE_TABLE_CLASSES = 2;
   localparam int BLOCK_COEFFS      = 64;
   localparam int ROW_ENTRIES       = 256;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;

   localparam int CODE_W   = 16;
   localparam int LEN_W    = 5;
   localparam int AMP_W    = 11;
   localparam int AMPLEN_W = 4;
   localparam int ENTRY_W  = LEN_W + CODE_W;
   localparam int SYM_W    = 8;
   localparam int POS_W    = 6;
   localparam int COEF_W   = 12;
   localparam int RUN_W    = 6;

   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(BLOCK_COEFFS - 1);
   localparam logic [RUN_W-1:0] RUN_MAX     = {RUN_W{1'b1}};
   localparam logic [SYM_W-1:0] SYM_ZRL     = 8'hF0;
   localparam logic [SYM_W-1:0] SYM_EOB     = 8'h00;
   localparam logic [LEN_W-1:0] MAX_CODE_LEN = 5'd16;

   localparam logic signed [COEF_W:0]   DC_LIMIT = 13'sd2047;
   localparam logic signed [COEF_W-1:0] AC_LIMIT = 12'sd1023;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic [1:0] COMP_NONE = 2'd3;

   // one unit of work handed from the front end to the table sequencer
   typedef struct packed {
      logic                is_load;
      logic                cls;
      logic                is_ac;
      logic [SYM_W-1:0]    sym;
      logic [ENTRY_W-1:0]  entry;
      logic [1:0]          n_zrl;
      logic                has_final;
      logic [AMP_W-1:0]    amp_bits;
      logic [AMPLEN_W-1:0] amp_len;
   } desc_type;

   // fields that ride alongside a table read
   typedef struct packed {
      logic [AMP_W-1:0]    amp_bits;
      logic [AMPLEN_W-1:0] amp_len;
      logic                last;
   } side_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code_bits;
      logic [LEN_W-1:0]    code_len;
      logic [AMP_W-1:0]    amp_bits;
      logic [AMPLEN_W-1:0] amp_len;
      logic                last;
   } res_type;

   typedef struct packed {
      logic mem_we;
      logic mem_re;
      logic rd_valid;
   } issue_stat_type;

   // size category: bit length of a magnitude
   function automatic logic [AMPLEN_W-1:0] size_cat(input logic [AMP_W-1:0] mag);
      logic [AMPLEN_W-1:0] s;
      s = '0;
      for (int i = 0; i < AMP_W; i++) begin
         if (mag[i]) s = AMPLEN_W'(i + 1);
      end
      return s;
   endfunction

   // amplitude bits; negatives send value-1, i.e. ones' complement of magnitude
   function automatic logic [AMP_W-1:0] amp_code(input logic signed [COEF_W-1:0] val,
                                                 input logic [AMPLEN_W-1:0] s);
      logic [COEF_W-1:0] mask;
      logic [COEF_W-1:0] raw;
      mask = (COEF_W'(1) << s) - COEF_W'(1);
      raw  = val[COEF_W-1] ? (val - COEF_W'(1)) : val;
      return AMP_W'(raw & mask);
   endfunction

endpackage

// ===== rtl/jbe_front.sv =====
// jbe_front: input transaction decode, DC prediction and zero-run tracking.
// Builds one descriptor per accepted transaction. Depends on jbe_pkg.
`timescale 1ns / 1ps

module jbe_front
   import jbe_pkg::*;
#(
   parameter int TABLE_CLASSES = JBE_TABLE_CLASSES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   desc_valid,
   output desc_type               desc,
   input  logic                   desc_take
);

   logic                     desc_valid_ff, desc_valid_in;
   desc_type                 desc_ff, desc_in;
   logic signed [COEF_W-1:0] prev_dc_ff [0:2];
   logic [RUN_W-1:0]         zero_run_ff, zero_run_in;

   logic                     accept;
   logic [1:0]               comp;
   logic                     cls;
   logic [POS_W-1:0]         pos;
   logic signed [COEF_W-1:0] coef;
   logic                     load_is_ac;
   logic [SYM_W-1:0]         load_symbol;
   logic [CODE_W-1:0]        load_code;
   logic [LEN_W-1:0]         load_length;
   logic [LEN_W-1:0]         len_sat;

   logic signed [COEF_W-1:0] pred;
   logic signed [COEF_W:0]   diff;
   logic signed [COEF_W-1:0] dc_val;
   logic signed [COEF_W-1:0] ac_val;
   logic signed [COEF_W-1:0] val;
   logic [COEF_W-1:0]        mag12;
   logic [AMPLEN_W-1:0]      size;
   logic [AMP_W-1:0]         amp;
   logic                     is_dc;
   logic                     ac_zero;
   logic                     at_end;

   assign comp        = req_tdata[1:0];
   assign cls         = (TABLE_CLASSES > 1) ? req_tdata[2] : 1'b0;
   assign pos         = req_tdata[8:3];
   assign coef        = req_tdata[20:9];
   assign load_is_ac  = req_tdata[21];
   assign load_symbol = req_tdata[29:22];
   assign load_code   = req_tdata[45:30];
   assign load_length = req_tdata[50:46];

   assign req_tready = !desc_valid_ff || desc_take;
   assign accept     = req_tvalid && req_tready;
   assign desc_valid = desc_valid_ff;
   assign desc       = desc_ff;

   assign len_sat = (load_length > MAX_CODE_LEN) ? MAX_CODE_LEN : load_length;

   always_comb begin
      case (comp)
         2'd0:    pred = prev_dc_ff[0];
         2'd1:    pred = prev_dc_ff[1];
         2'd2:    pred = prev_dc_ff[2];
         default: pred = '0;
      endcase
   end

   always_comb begin
      diff = {coef[COEF_W-1], coef} - {pred[COEF_W-1], pred};
      if (diff > DC_LIMIT) begin
         dc_val = COEF_W'(DC_LIMIT);
      end else if (diff < -DC_LIMIT) begin
         dc_val = COEF_W'(-DC_LIMIT);
      end else begin
         dc_val = diff[COEF_W-1:0];
      end

      if (coef > AC_LIMIT) begin
         ac_val = AC_LIMIT;
      end else if (coef < -AC_LIMIT) begin
         ac_val = -AC_LIMIT;
      end else begin
         ac_val = coef;
      end
   end

   assign is_dc   = (pos == '0);
   assign ac_zero = (ac_val == '0);
   assign at_end  = (pos == LAST_POS);
   assign val     = is_dc ? dc_val : ac_val;
   assign mag12   = val[COEF_W-1] ? (COEF_W'(0) - val) : val;
   assign size    = size_cat(mag12[AMP_W-1:0]);
   assign amp     = amp_code(val, size);

   always_comb begin
      desc_in          = '0;
      desc_in.cls      = cls;
      zero_run_in      = zero_run_ff;
      if (req_tuser == OP_LOAD) begin
         desc_in.is_load = 1'b1;
         desc_in.is_ac   = load_is_ac;
         desc_in.sym     = load_symbol;
         desc_in.entry   = {len_sat, load_code};
      end else if (is_dc) begin
         desc_in.is_ac     = 1'b0;
         desc_in.sym       = SYM_W'(size);
         desc_in.has_final = 1'b1;
         desc_in.amp_bits  = amp;
         desc_in.amp_len   = size;
         zero_run_in       = '0;
      end else if (ac_zero) begin
         desc_in.is_ac     = 1'b1;
         desc_in.sym       = SYM_EOB;
         desc_in.has_final = at_end;
         zero_run_in       = at_end ? '0 :
                             (zero_run_ff != RUN_MAX) ? zero_run_ff + RUN_W'(1) : zero_run_ff;
      end else begin
         // each ZRL takes 16 zeros; the run never exceeds 63, so at most three
         desc_in.is_ac     = 1'b1;
         desc_in.n_zrl     = zero_run_ff[5:4];
         desc_in.sym       = {zero_run_ff[3:0], size};
         desc_in.has_final = 1'b1;
         desc_in.amp_bits  = amp;
         desc_in.amp_len   = size;
         zero_run_in       = '0;
      end
   end

   always_comb begin
      desc_valid_in = desc_valid_ff;
      if (accept) begin
         desc_valid_in = 1'b1;
      end else if (desc_take) begin
         desc_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         zero_run_ff   <= '0;
         prev_dc_ff[0] <= '0;
         prev_dc_ff[1] <= '0;
         prev_dc_ff[2] <= '0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         if (accept && req_tuser == OP_ENCODE) begin
            zero_run_ff <= zero_run_in;
            if (is_dc && comp != COMP_NONE) begin
               prev_dc_ff[comp] <= coef;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

// ===== rtl/jbe_table_ram.sv =====
// jbe_table_ram: single-port code table memory, registered read data.
// Holds code word and length per symbol. Depends on jbe_pkg.
`timescale 1ns / 1ps

module jbe_table_ram
   import jbe_pkg::*;
#(
   parameter int DEPTH = JBE_TABLE_CLASSES * 2 * ROW_ENTRIES,
   parameter int WIDTH = ENTRY_W
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

// ===== rtl/jbe_issue.sv =====
// jbe_issue: walks each descriptor through the code table, one access a cycle.
// Issues a read only when the result buffer has a slot reserved. Depends on jbe_pkg.
`timescale 1ns / 1ps

module jbe_issue
   import jbe_pkg::*;
#(
   parameter int TABLE_CLASSES = JBE_TABLE_CLASSES,
   parameter int ADDR_W        = $clog2(TABLE_CLASSES * 2 * ROW_ENTRIES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_valid,
   input  desc_type           desc,
   output logic               desc_take,
   input  logic [1:0]         ob_count,
   input  logic               ob_pop,
   output logic               mem_we,
   output logic               mem_re,
   output logic [ADDR_W-1:0]  mem_addr,
   output logic [ENTRY_W-1:0] mem_wdata,
   output logic               rd_valid,
   output side_type           rd_side,
   output issue_stat_type     stat
);

   logic [1:0]  k_ff, k_in;
   logic        rd_valid_ff;
   side_type    side_ff, side_in;
   logic [2:0]  occ_next;
   logic        room;
   logic        zrl_step;
   logic        sel_ac;
   logic [SYM_W-1:0] sel_sym;

   // buffer holds two; a read issued now passes rd_valid_ff before it lands in the buffer
   assign occ_next = 3'(ob_count) + 3'(rd_valid_ff) - 3'(ob_pop);
   assign room     = (occ_next < 3'd2);
   assign zrl_step = (k_ff != desc.n_zrl);

   always_comb begin
      desc_take = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      k_in      = k_ff;
      if (desc_valid) begin
         if (desc.is_load) begin
            mem_we    = 1'b1;
            desc_take = 1'b1;
         end else if (!desc.has_final) begin
            desc_take = 1'b1;
         end else if (room) begin
            mem_re = 1'b1;
            if (zrl_step) begin
               k_in = k_ff + 2'd1;
            end else begin
               k_in      = '0;
               desc_take = 1'b1;
            end
         end
      end
   end

   always_comb begin
      sel_ac  = desc.is_ac;
      sel_sym = desc.sym;
      side_in = '0;
      if (!desc.is_load && zrl_step) begin
         sel_ac  = 1'b1;
         sel_sym = SYM_ZRL;
      end else begin
         side_in.amp_bits = desc.amp_bits;
         side_in.amp_len  = desc.amp_len;
         side_in.last     = 1'b1;
      end
   end

   assign mem_addr  = ADDR_W'({desc.cls, sel_ac, sel_sym});
   assign mem_wdata = desc.entry;
   assign rd_valid  = rd_valid_ff;
   assign rd_side   = side_ff;

   assign stat.mem_we   = mem_we;
   assign stat.mem_re   = mem_re;
   assign stat.rd_valid = rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         k_ff        <= k_in;
         rd_valid_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         side_ff <= side_in;
      end
   end

endmodule

// ===== rtl/jbe_out_buf.sv =====
// jbe_out_buf: two-entry result queue in front of the rsp channel.
// Decouples table reads from downstream stalls. Depends on jbe_pkg.
`timescale 1ns / 1ps

module jbe_out_buf
   import jbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  res_type    push_data,
   output logic       out_valid,
   input  logic       out_ready,
   output res_type    out_data,
   output logic [1:0] count,
   output logic       pop
);

   res_type    entry_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign count     = count_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/jpeg_block_entropy_encoder_top.sv =====
// JPEG baseline entropy coder, one quantized coefficient (or one code table
// load) per req transaction, zero or more code/amplitude results per item on
// rsp. The block accepts one transaction every cycle while each item gives at
// most one result and rsp keeps up. Each result needs one read of the single-port
// code table, so an item giving k results (k is 1 to 4, four only when three ZRL
// symbols precede a coefficient) holds the input until its last read is issued.
// Loads and items giving no result never wait for buffer room. Each result passes
// the descriptor and table read registers into the result buffer, which drives
// rsp. Once the two-entry buffer is committed, rsp stalls hold the input. The
// table has no reset: every code entry that a coefficient will use must be loaded
// first. Depends on jbe_pkg, jbe_front, jbe_table_ram, jbe_issue, jbe_out_buf.
`timescale 1ns / 1ps

module jpeg_block_entropy_encoder_top
   import jbe_pkg::*;
#(
   parameter int TABLE_CLASSES = JBE_TABLE_CLASSES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // component[1:0], table_class[2], position[8:3], coefficient[20:9],
   // load_is_ac[21], load_symbol[29:22], load_code[45:30], load_length[50:46]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // code_bits[15:0], code_len[20:16], amp_bits[31:21], amp_len[35:32]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int STORE_DEPTH = TABLE_CLASSES * 2 * ROW_ENTRIES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic               desc_valid;
   desc_type           desc;
   logic               desc_take;
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;
   logic               rd_valid;
   side_type           rd_side;
   issue_stat_type     stat;
   res_type            push_data;
   res_type            out_data;
   logic [1:0]         ob_count;
   logic               ob_pop;

   jbe_front #(
      .TABLE_CLASSES(TABLE_CLASSES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_take  (desc_take)
   );

   jbe_issue #(
      .TABLE_CLASSES(TABLE_CLASSES),
      .ADDR_W       (ADDR_W)
   ) u_issue (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_take  (desc_take),
      .ob_count   (ob_count),
      .ob_pop     (ob_pop),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .rd_valid   (rd_valid),
      .rd_side    (rd_side),
      .stat       (stat)
   );

   jbe_table_ram #(
      .DEPTH(STORE_DEPTH),
      .WIDTH(ENTRY_W)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign push_data.code_bits = mem_rdata[CODE_W-1:0];
   assign push_data.code_len  = mem_rdata[ENTRY_W-1:CODE_W];
   assign push_data.amp_bits  = rd_side.amp_bits;
   assign push_data.amp_len   = rd_side.amp_len;
   assign push_data.last      = rd_side.last;

   jbe_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (rd_valid),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .count     (ob_count),
      .pop       (ob_pop)
   );

   assign rsp_tdata = {4'b0000, out_data.amp_len, out_data.amp_bits,
                       out_data.code_len, out_data.code_bits};
   assign rsp_tlast = out_data.last;

   // single table port: a load and a lookup never share a cycle
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stat.mem_we && stat.mem_re))
      else $error("code table written and read in the same cycle");

   // reserved slots never exceed the result buffer
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (3'(ob_count) + 3'(stat.rd_valid)) <= 3'd2)
      else $error("result buffer over-committed");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rd_valid |-> (ob_count != 2'd2 || ob_pop))
      else $error("result pushed into full buffer");

   // a descriptor is never retired by the sequencer without being present
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      desc_take |-> desc_valid)
      else $error("descriptor retired while empty");

endmodule
